### hw/rtl/cluster_bounding_box_centroid_defines.svh
// Assertion macros for the cluster bounding box and centroid block.
// Included by the checker module; depends on nothing else.
`ifndef CLUSTER_BOUNDING_BOX_CENTROID_DEFINES_SVH
`define CLUSTER_BOUNDING_BOX_CENTROID_DEFINES_SVH

// Same-cycle implication, disabled while reset is held.
`define CBBC_ASSERT_SAME(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, disabled while reset is held.
`define CBBC_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

### hw/rtl/cbbc_pkg.sv
// Shared constants and types for the cluster bounding box and centroid block.
// Used by every module of the block; depends on nothing.
package cbbc_pkg;

    // Largest number of points kept per cluster, and coordinate width.
    localparam int MAX_POINTS = 32768;
    localparam int COORD_W    = 16;

    // Point count, sum and queue widths follow from the constants above.
    localparam int CNT_W   = $clog2(MAX_POINTS + 1);
    localparam int SUM_W   = COORD_W + $clog2(MAX_POINTS) + 1;
    localparam int Q_DEPTH = 2;
    localparam int Q_AW    = $clog2(Q_DEPTH);

    // Summary of one finished cluster, handed from front to back.
    typedef struct packed {
        logic signed [SUM_W-1:0] sum_x;
        logic signed [SUM_W-1:0] sum_y;
        logic [CNT_W-1:0]        count;
        logic [COORD_W-1:0]      width;
        logic [COORD_W-1:0]      length;
        logic                    dropped;
    } t_clus;

    // Queue status seen by both sides.
    typedef struct packed {
        logic full;
        logic empty;
    } t_q_stat;

endpackage

### hw/rtl/cluster_bounding_box_centroid.sv
// Top level of the cluster bounding box and centroid block.
// Connects front end, summary queue and divider back end; depends on cbbc_pkg.
//
// Usage: points of a cluster arrive on the input channel (i_valid / o_stall)
// as signed x and y millimetres; i_last_point marks the final point. Each
// point is one transaction, so points stream at one per clock while o_stall
// is low. The final point closes the cluster and its summary enters a
// two-entry queue. The back end divides the sums by the count with a
// restoring divider, one quotient bit per cycle. An idle back end pops the
// summary from the queue, runs the divider and then raises o_valid
// (o_valid / i_stall); the result is taken at an edge where i_stall is low.
// A new summary is popped only after that result has left; the front
// raises o_stall only while the queue holds two waiting clusters, which
// happens when clusters shorter than the divider time arrive back to back
// or results are stalled. While i_stall is high the result and o_valid hold.
// Points past the maximum count are dropped and reported through
// o_overflow_flag. Reset clears all sums, counts, the queue and o_valid.
module cluster_bounding_box_centroid (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    input  logic                                i_valid,
    output logic                                o_stall,
    input  logic signed [cbbc_pkg::COORD_W-1:0] i_x_coord,
    input  logic signed [cbbc_pkg::COORD_W-1:0] i_y_coord,
    input  logic                                i_last_point,
    output logic                                o_valid,
    input  logic                                i_stall,
    output logic signed [cbbc_pkg::COORD_W-1:0] o_centroid_x,
    output logic signed [cbbc_pkg::COORD_W-1:0] o_centroid_y,
    output logic [cbbc_pkg::COORD_W-1:0]        o_extent_width,
    output logic [cbbc_pkg::COORD_W-1:0]        o_extent_length,
    output logic [cbbc_pkg::COORD_W-1:0]        o_point_total,
    output logic                                o_overflow_flag
);

    cbbc_pkg::t_clus   push_clus, head_clus;
    cbbc_pkg::t_q_stat q_stat;
    logic              push;
    logic              pop;
    logic              accept;

    // A point transaction completes when the queue has room.
    assign o_stall = q_stat.full;
    assign accept  = i_valid && !o_stall;

    cbbc_front u_front (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_accept (accept),
        .i_x      (i_x_coord),
        .i_y      (i_y_coord),
        .i_last   (i_last_point),
        .o_push   (push),
        .o_clus   (push_clus)
    );

    cbbc_fifo u_fifo (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (push),
        .i_data  (push_clus),
        .i_pop   (pop),
        .o_data  (head_clus),
        .o_stat  (q_stat)
    );

    cbbc_back u_back (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_clus          (head_clus),
        .i_q_stat        (q_stat),
        .o_pop           (pop),
        .o_valid         (o_valid),
        .i_stall         (i_stall),
        .o_centroid_x    (o_centroid_x),
        .o_centroid_y    (o_centroid_y),
        .o_extent_width  (o_extent_width),
        .o_extent_length (o_extent_length),
        .o_point_total   (o_point_total),
        .o_overflow_flag (o_overflow_flag)
    );

endmodule

### hw/rtl/cbbc_front.sv
// Front end: accepts points, keeps running minima, maxima, sums and count,
// and pushes a cluster summary on the last point. Depends on cbbc_pkg.
module cbbc_front (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    input  logic                                i_accept,
    input  logic signed [cbbc_pkg::COORD_W-1:0] i_x,
    input  logic signed [cbbc_pkg::COORD_W-1:0] i_y,
    input  logic                                i_last,
    output logic                                o_push,
    output cbbc_pkg::t_clus                     o_clus
);

    logic signed [cbbc_pkg::COORD_W-1:0] r_low_x, r_high_x, r_low_y, r_high_y;
    logic signed [cbbc_pkg::COORD_W-1:0] n_low_x, n_high_x, n_low_y, n_high_y;
    logic signed [cbbc_pkg::SUM_W-1:0]   r_sum_x, r_sum_y, n_sum_x, n_sum_y;
    logic [cbbc_pkg::CNT_W-1:0]          r_count, n_count;
    logic                                r_dropped, n_dropped;
    logic                                full;
    logic                                first;

    assign full  = (r_count >= cbbc_pkg::CNT_W'(cbbc_pkg::MAX_POINTS));
    assign first = (r_count == '0);

    // Update the running statistics with an accepted point.
    always_comb begin
        n_low_x   = r_low_x;
        n_high_x  = r_high_x;
        n_low_y   = r_low_y;
        n_high_y  = r_high_y;
        n_sum_x   = r_sum_x;
        n_sum_y   = r_sum_y;
        n_count   = r_count;
        n_dropped = r_dropped;
        if (i_accept) begin
            if (full) begin
                n_dropped = 1'b1;
            end else begin
                if (first) begin
                    n_low_x  = i_x;
                    n_high_x = i_x;
                    n_low_y  = i_y;
                    n_high_y = i_y;
                end else begin
                    if (i_x < r_low_x)  n_low_x  = i_x;
                    if (i_x > r_high_x) n_high_x = i_x;
                    if (i_y < r_low_y)  n_low_y  = i_y;
                    if (i_y > r_high_y) n_high_y = i_y;
                end
                n_sum_x = r_sum_x + cbbc_pkg::SUM_W'(i_x);
                n_sum_y = r_sum_y + cbbc_pkg::SUM_W'(i_y);
                n_count = r_count + 1'b1;
            end
        end
    end

    // The summary carries the values after this point is taken in.
    assign o_push         = i_accept && i_last;
    assign o_clus.sum_x   = n_sum_x;
    assign o_clus.sum_y   = n_sum_y;
    assign o_clus.count   = n_count;
    assign o_clus.width   = cbbc_pkg::COORD_W'(n_high_x - n_low_x);
    assign o_clus.length  = cbbc_pkg::COORD_W'(n_high_y - n_low_y);
    assign o_clus.dropped = n_dropped;

    // Statistics registers; the last point clears them for the next cluster.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_sum_x   <= '0;
            r_sum_y   <= '0;
            r_count   <= '0;
            r_dropped <= 1'b0;
        end else if (o_push) begin
            r_sum_x   <= '0;
            r_sum_y   <= '0;
            r_count   <= '0;
            r_dropped <= 1'b0;
        end else begin
            r_sum_x   <= n_sum_x;
            r_sum_y   <= n_sum_y;
            r_count   <= n_count;
            r_dropped <= n_dropped;
        end
    end

    // Minima and maxima are reloaded by the first point of each cluster.
    always_ff @(posedge i_clk) begin
        r_low_x  <= n_low_x;
        r_high_x <= n_high_x;
        r_low_y  <= n_low_y;
        r_high_y <= n_high_y;
    end

endmodule

### hw/rtl/cbbc_fifo.sv
// Short queue of cluster summaries between the front and back ends.
// Depends on cbbc_pkg for the entry type and depth.
module cbbc_fifo (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_push,
    input  cbbc_pkg::t_clus   i_data,
    input  logic              i_pop,
    output cbbc_pkg::t_clus   o_data,
    output cbbc_pkg::t_q_stat o_stat
);

    cbbc_pkg::t_clus             r_mem [cbbc_pkg::Q_DEPTH];
    logic [cbbc_pkg::Q_AW-1:0]   r_wr_ptr, r_rd_ptr;
    logic [cbbc_pkg::Q_AW:0]     r_fill;

    assign o_stat.full  = (r_fill == (cbbc_pkg::Q_AW+1)'(cbbc_pkg::Q_DEPTH));
    assign o_stat.empty = (r_fill == '0);
    assign o_data       = r_mem[r_rd_ptr];

    // Entry storage.
    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[r_wr_ptr] <= i_data;
        end
    end

    // Pointers and fill level.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_fill   <= '0;
        end else begin
            if (i_push) begin
                r_wr_ptr <= (r_wr_ptr == cbbc_pkg::Q_AW'(cbbc_pkg::Q_DEPTH - 1))
                            ? '0 : r_wr_ptr + 1'b1;
            end
            if (i_pop) begin
                r_rd_ptr <= (r_rd_ptr == cbbc_pkg::Q_AW'(cbbc_pkg::Q_DEPTH - 1))
                            ? '0 : r_rd_ptr + 1'b1;
            end
            if (i_push && !i_pop) begin
                r_fill <= r_fill + 1'b1;
            end else if (i_pop && !i_push) begin
                r_fill <= r_fill - 1'b1;
            end
        end
    end

endmodule

### hw/rtl/cbbc_back.sv
// Back end: takes one cluster summary at a time, divides both sums by the
// count one quotient bit per cycle, and holds the result. Depends on cbbc_pkg.
module cbbc_back (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  cbbc_pkg::t_clus               i_clus,
    input  cbbc_pkg::t_q_stat             i_q_stat,
    output logic                          o_pop,
    output logic                          o_valid,
    input  logic                          i_stall,
    output logic [cbbc_pkg::COORD_W-1:0]  o_centroid_x,
    output logic [cbbc_pkg::COORD_W-1:0]  o_centroid_y,
    output logic [cbbc_pkg::COORD_W-1:0]  o_extent_width,
    output logic [cbbc_pkg::COORD_W-1:0]  o_extent_length,
    output logic [cbbc_pkg::COORD_W-1:0]  o_point_total,
    output logic                          o_overflow_flag
);

    localparam logic [1:0] S_IDLE = 2'd0;
    localparam logic [1:0] S_DIV  = 2'd1;
    localparam logic [1:0] S_OUT  = 2'd2;
    localparam int STEP_W = $clog2(cbbc_pkg::SUM_W);

    // Restoring divider state: partial remainder and dividend/quotient shifter.
    typedef struct packed {
        logic [cbbc_pkg::CNT_W-1:0] rem;
        logic [cbbc_pkg::SUM_W-1:0] quo;
    } t_div;

    logic [1:0]                  r_state;
    logic [STEP_W-1:0]           r_step;
    t_div                        r_div_x, r_div_y;
    t_div                        n_div_x, n_div_y;
    logic                        r_neg_x, r_neg_y;
    logic [cbbc_pkg::CNT_W-1:0]  r_den;
    logic [cbbc_pkg::SUM_W-1:0]  mag_x, mag_y;
    logic [cbbc_pkg::SUM_W-1:0]  fin_x, fin_y;
    logic                        last_step;

    // One quotient bit: shift in the next dividend bit and try a subtract.
    function automatic t_div div_step(input t_div cur, input logic [cbbc_pkg::CNT_W-1:0] den);
        t_div                     nxt;
        logic [cbbc_pkg::CNT_W:0] rem_sh;
        logic [cbbc_pkg::CNT_W:0] diff;
        rem_sh = {cur.rem, cur.quo[cbbc_pkg::SUM_W-1]};
        diff   = rem_sh - {1'b0, den};
        if (rem_sh >= {1'b0, den}) begin
            nxt.rem = diff[cbbc_pkg::CNT_W-1:0];
            nxt.quo = {cur.quo[cbbc_pkg::SUM_W-2:0], 1'b1};
        end else begin
            nxt.rem = rem_sh[cbbc_pkg::CNT_W-1:0];
            nxt.quo = {cur.quo[cbbc_pkg::SUM_W-2:0], 1'b0};
        end
        return nxt;
    endfunction

    // Magnitudes of the incoming sums; the sign is restored after dividing.
    assign mag_x = i_clus.sum_x[cbbc_pkg::SUM_W-1] ? -i_clus.sum_x : i_clus.sum_x;
    assign mag_y = i_clus.sum_y[cbbc_pkg::SUM_W-1] ? -i_clus.sum_y : i_clus.sum_y;

    assign n_div_x   = div_step(r_div_x, r_den);
    assign n_div_y   = div_step(r_div_y, r_den);
    assign fin_x     = r_neg_x ? -n_div_x.quo : n_div_x.quo;
    assign fin_y     = r_neg_y ? -n_div_y.quo : n_div_y.quo;
    assign last_step = (r_step == STEP_W'(cbbc_pkg::SUM_W - 1));

    assign o_pop   = (r_state == S_IDLE) && !i_q_stat.empty;
    assign o_valid = (r_state == S_OUT);

    // Sequencer: load a summary, run the divider, present the result.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_step  <= '0;
        end else begin
            unique case (r_state)
                S_IDLE: begin
                    if (o_pop) begin
                        r_state <= S_DIV;
                        r_step  <= '0;
                    end
                end
                S_DIV: begin
                    r_step <= r_step + 1'b1;
                    if (last_step) begin
                        r_state <= S_OUT;
                    end
                end
                S_OUT: begin
                    if (!i_stall) begin
                        r_state <= S_IDLE;
                    end
                end
                default: begin
                    r_state <= S_IDLE;
                end
            endcase
        end
    end

    // Divider and result datapath.
    always_ff @(posedge i_clk) begin
        if (o_pop) begin
            r_div_x.rem     <= '0;
            r_div_x.quo     <= mag_x;
            r_div_y.rem     <= '0;
            r_div_y.quo     <= mag_y;
            r_neg_x         <= i_clus.sum_x[cbbc_pkg::SUM_W-1];
            r_neg_y         <= i_clus.sum_y[cbbc_pkg::SUM_W-1];
            r_den           <= i_clus.count;
            o_extent_width  <= i_clus.width;
            o_extent_length <= i_clus.length;
            o_point_total   <= cbbc_pkg::COORD_W'(i_clus.count);
            o_overflow_flag <= i_clus.dropped;
        end else if (r_state == S_DIV) begin
            r_div_x <= n_div_x;
            r_div_y <= n_div_y;
            if (last_step) begin
                o_centroid_x <= fin_x[cbbc_pkg::COORD_W-1:0];
                o_centroid_y <= fin_y[cbbc_pkg::COORD_W-1:0];
            end
        end
    end

endmodule

### hw/rtl/cbbc_chk.sv
// Port-level checker for the cluster bounding box and centroid block,
// bound to the top level. Depends on cbbc_pkg and the assertion macro header.
`include "cluster_bounding_box_centroid_defines.svh"

module cbbc_chk (
    input logic                          i_clk,
    input logic                          i_rst_n,
    input logic                          o_valid,
    input logic                          i_stall,
    input logic [cbbc_pkg::COORD_W-1:0]  o_centroid_x,
    input logic [cbbc_pkg::COORD_W-1:0]  o_centroid_y,
    input logic [cbbc_pkg::COORD_W-1:0]  o_point_total,
    input logic                          o_overflow_flag
);

    // A stalled result stays offered.
    `CBBC_ASSERT_NEXT(a_valid_hold, i_clk, i_rst_n, o_valid && i_stall, o_valid, "result dropped while stalled")

    // A stalled result keeps its values.
    `CBBC_ASSERT_NEXT(a_data_hold, i_clk, i_rst_n, o_valid && i_stall, $stable(o_centroid_x) && $stable(o_centroid_y) && $stable(o_point_total), "result changed while stalled")

    // Every reported cluster holds at least one point.
    `CBBC_ASSERT_SAME(a_total_nonzero, i_clk, i_rst_n, o_valid, o_point_total != '0, "empty cluster reported")

    // Points are only dropped once the cluster is full.
    `CBBC_ASSERT_SAME(a_overflow_full, i_clk, i_rst_n, o_valid && o_overflow_flag, o_point_total == cbbc_pkg::COORD_W'(cbbc_pkg::MAX_POINTS), "overflow without full cluster")

endmodule

bind cluster_bounding_box_centroid cbbc_chk u_chk (
    .i_clk           (i_clk),
    .i_rst_n         (i_rst_n),
    .o_valid         (o_valid),
    .i_stall         (i_stall),
    .o_centroid_x    (o_centroid_x),
    .o_centroid_y    (o_centroid_y),
    .o_point_total   (o_point_total),
    .o_overflow_flag (o_overflow_flag)
);

### dv/cluster_summary_checker.sv
`timescale 1ns / 100ps
// Scoreboard for cluster_bounding_box_centroid: watches the point and result channels,
// predicts each cluster summary and compares. Depends on cbbc_pkg only.
module cluster_summary_checker (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    input  logic                                i_in_valid,
    input  logic                                i_in_stall,
    input  logic signed [cbbc_pkg::COORD_W-1:0] i_x,
    input  logic signed [cbbc_pkg::COORD_W-1:0] i_y,
    input  logic                                i_last,
    input  logic                                i_out_valid,
    input  logic                                i_out_stall,
    input  logic signed [cbbc_pkg::COORD_W-1:0] i_centroid_x,
    input  logic signed [cbbc_pkg::COORD_W-1:0] i_centroid_y,
    input  logic [cbbc_pkg::COORD_W-1:0]        i_extent_width,
    input  logic [cbbc_pkg::COORD_W-1:0]        i_extent_length,
    input  logic [cbbc_pkg::COORD_W-1:0]        i_point_total,
    input  logic                                i_overflow_flag,
    output int                                  o_errors,
    output int                                  o_pending,
    output int                                  o_checked,
    output int                                  o_points,
    output int                                  o_spilled
);

    localparam int CW           = cbbc_pkg::COORD_W;
    localparam int REPORT_LIMIT = 10;

    // One finished cluster as it should leave the block.
    typedef struct packed {
        logic signed [CW-1:0] centroid_x;
        logic signed [CW-1:0] centroid_y;
        logic [CW-1:0]        width;
        logic [CW-1:0]        length;
        logic [CW-1:0]        total;
        logic                 spill;
    } t_cluster_summary;

    t_cluster_summary summaries_due[$];

    // Running box, sums and count of the cluster being collected.
    logic signed [CW-1:0] box_min_x = '0;
    logic signed [CW-1:0] box_max_x = '0;
    logic signed [CW-1:0] box_min_y = '0;
    logic signed [CW-1:0] box_max_y = '0;
    longint               run_sum_x = 0;
    longint               run_sum_y = 0;
    int unsigned          kept      = 0;
    bit                   dropped   = 1'b0;

    // Folds one accepted point into the running cluster. On the final point the
    // expected summary is queued and the running cluster starts over.
    function automatic void absorb_point(input logic signed [CW-1:0] x,
                                         input logic signed [CW-1:0] y,
                                         input logic last);
        t_cluster_summary s;
        longint           quot;
        int               span;
        if (kept >= cbbc_pkg::MAX_POINTS) begin
            // A full cluster drops the point but remembers that it did.
            dropped = 1'b1;
        end else begin
            if (kept == 0) begin
                box_min_x = x;
                box_max_x = x;
                box_min_y = y;
                box_max_y = y;
            end else begin
                if (x < box_min_x) box_min_x = x;
                if (x > box_max_x) box_max_x = x;
                if (y < box_min_y) box_min_y = y;
                if (y > box_max_y) box_max_y = y;
            end
            run_sum_x += x;
            run_sum_y += y;
            kept++;
        end
        if (last) begin
            // Integer division truncates toward zero, as the mean requires.
            quot = run_sum_x / longint'(kept);
            s.centroid_x = quot[CW-1:0];
            quot = run_sum_y / longint'(kept);
            s.centroid_y = quot[CW-1:0];
            span = int'(box_max_x) - int'(box_min_x);
            s.width = span[CW-1:0];
            span = int'(box_max_y) - int'(box_min_y);
            s.length = span[CW-1:0];
            s.total = kept[CW-1:0];
            s.spill = dropped;
            summaries_due = {summaries_due, s};
            if (dropped) o_spilled++;
            box_min_x = '0;
            box_max_x = '0;
            box_min_y = '0;
            box_max_y = '0;
            run_sum_x = 0;
            run_sum_y = 0;
            kept = 0;
            dropped = 1'b0;
        end
    endfunction

    // Both channels are sampled at the rising edge; the result side is handled
    // first so that the order within the edge is fixed.
    always @(posedge i_clk) begin : watch
        t_cluster_summary got;
        t_cluster_summary want;
        if (i_rst_n) begin
            if (i_out_valid && !i_out_stall) begin
                got.centroid_x = i_centroid_x;
                got.centroid_y = i_centroid_y;
                got.width      = i_extent_width;
                got.length     = i_extent_length;
                got.total      = i_point_total;
                got.spill      = i_overflow_flag;
                if (summaries_due.size() == 0) begin
                    o_errors++;
                    if (o_errors <= REPORT_LIMIT) begin
                        $display("ERROR at %0t: result transaction with no cluster pending",
                                 $time);
                    end
                end else begin
                    want = summaries_due.pop_front();
                    o_checked++;
                    if (got !== want) begin
                        o_errors++;
                        if (o_errors <= REPORT_LIMIT) begin
                            $display("ERROR at %0t: cluster summary %0d differs", $time,
                                     o_checked);
                            $display("  expected cx %0d cy %0d w %0d l %0d n %0d ovf %0b",
                                     want.centroid_x, want.centroid_y, want.width,
                                     want.length, want.total, want.spill);
                            $display("  actual   cx %0d cy %0d w %0d l %0d n %0d ovf %0b",
                                     got.centroid_x, got.centroid_y, got.width,
                                     got.length, got.total, got.spill);
                        end
                    end
                end
            end
            if (i_in_valid && !i_in_stall) begin
                o_points++;
                absorb_point(i_x, i_y, i_last);
            end
        end
        o_pending = summaries_due.size();
    end

endmodule

### dv/tb_top.sv
`timescale 1ns / 100ps
// Testbench top for cluster_bounding_box_centroid: clock, reset, point stimulus,
// result back-pressure and verdict. Depends on cbbc_pkg, the block and cluster_summary_checker.
module tb_top;

    localparam int CW            = cbbc_pkg::COORD_W;
    localparam int RANDOM_POINTS = 1280;
    localparam int HOLD_CYCLES   = 400;
    localparam int QUIET_LIMIT   = 4000;
    localparam int SETTLE_CYCLES = 100;

    localparam logic signed [CW-1:0] COORD_MIN = {1'b1, {(CW-1){1'b0}}};
    localparam logic signed [CW-1:0] COORD_MAX = {1'b0, {(CW-1){1'b1}}};

    // Patterns the result side cycles through.
    typedef enum int {
        STALL_NONE,
        STALL_LIGHT,
        STALL_HEAVY,
        STALL_PERIODIC
    } t_stall_mode;

    logic                 i_clk;
    logic                 i_rst_n;
    logic                 i_valid;
    logic                 o_stall;
    logic signed [CW-1:0] i_x_coord;
    logic signed [CW-1:0] i_y_coord;
    logic                 i_last_point;
    logic                 o_valid;
    logic                 i_stall;
    logic signed [CW-1:0] o_centroid_x;
    logic signed [CW-1:0] o_centroid_y;
    logic [CW-1:0]        o_extent_width;
    logic [CW-1:0]        o_extent_length;
    logic [CW-1:0]        o_point_total;
    logic                 o_overflow_flag;

    int errors;
    int pending;
    int checked;
    int points;
    int spilled;

    logic in_taken = 1'b0;
    int   burst_left;
    int   sent_points;
    bit   steady;
    bit   hold_req;

    cluster_bounding_box_centroid u_dut (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_valid         (i_valid),
        .o_stall         (o_stall),
        .i_x_coord       (i_x_coord),
        .i_y_coord       (i_y_coord),
        .i_last_point    (i_last_point),
        .o_valid         (o_valid),
        .i_stall         (i_stall),
        .o_centroid_x    (o_centroid_x),
        .o_centroid_y    (o_centroid_y),
        .o_extent_width  (o_extent_width),
        .o_extent_length (o_extent_length),
        .o_point_total   (o_point_total),
        .o_overflow_flag (o_overflow_flag)
    );

    cluster_summary_checker u_checker (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_in_valid      (i_valid),
        .i_in_stall      (o_stall),
        .i_x             (i_x_coord),
        .i_y             (i_y_coord),
        .i_last          (i_last_point),
        .i_out_valid     (o_valid),
        .i_out_stall     (i_stall),
        .i_centroid_x    (o_centroid_x),
        .i_centroid_y    (o_centroid_y),
        .i_extent_width  (o_extent_width),
        .i_extent_length (o_extent_length),
        .i_point_total   (o_point_total),
        .i_overflow_flag (o_overflow_flag),
        .o_errors        (errors),
        .o_pending       (pending),
        .o_checked       (checked),
        .o_points        (points),
        .o_spilled       (spilled)
    );

    // Free-running clock, 20 ns period.
    initial begin
        i_clk = 1'b0;
        forever #10 i_clk = ~i_clk;
    end

    // Records whether the point transaction offered in the last cycle was taken,
    // so the driver can decide at the falling edge.
    always @(posedge i_clk) begin
        in_taken <= (i_valid === 1'b1) && (o_stall === 1'b0);
    end

    // Ends the run if neither channel moves for too long.
    initial begin : watchdog
        int quiet;
        quiet = 0;
        while (quiet < QUIET_LIMIT) begin
            @(posedge i_clk);
            if ((i_valid && !o_stall) || (o_valid && !i_stall)) begin
                quiet = 0;
            end else begin
                quiet++;
            end
        end
        $display("Watchdog: no transaction for %0d cycles", QUIET_LIMIT);
        $display("Simulation FAILED");
        $finish;
    end

    // Result-side stall pattern, plus one long hold-off on request.
    initial begin : receiver
        t_stall_mode mode;
        int          left;
        int          tick;
        i_stall = 1'b0;
        mode = STALL_NONE;
        left = 0;
        tick = 0;
        forever begin
            @(negedge i_clk);
            if (hold_req) begin
                i_stall <= 1'b1;
                repeat (HOLD_CYCLES) @(negedge i_clk);
                hold_req = 1'b0;
            end else begin
                if (left == 0) begin
                    mode = t_stall_mode'($urandom_range(0, 3));
                    left = $urandom_range(100, 600);
                end
                left--;
                tick++;
                case (mode)
                    STALL_NONE:  i_stall <= 1'b0;
                    STALL_LIGHT: i_stall <= ($urandom_range(0, 9) == 0);
                    STALL_HEAVY: i_stall <= ($urandom_range(0, 9) < 6);
                    default:     i_stall <= ((tick % 23) < 7);
                endcase
            end
        end
    end

    // Coordinate mix: the two extremes, values around zero and anything at all.
    function automatic logic signed [CW-1:0] pick_coord();
        logic signed [CW-1:0] v;
        case ($urandom_range(0, 9))
            0: v = COORD_MIN;
            1: v = COORD_MAX;
            2, 3: begin
                v = CW'($urandom_range(0, 200));
                v = v - CW'(100);
            end
            default: v = CW'($urandom());
        endcase
        return v;
    endfunction

    task automatic idle_sender(input int cycles);
        i_valid <= 1'b0;
        repeat (cycles) @(negedge i_clk);
    endtask

    // Offers one point and holds it until the block takes it. Outside steady
    // stretches the sender works in bursts with gaps of random length.
    task automatic offer_point(input logic signed [CW-1:0] x,
                               input logic signed [CW-1:0] y,
                               input logic last);
        int gap;
        if (burst_left == 0) begin
            burst_left = $urandom_range(1, 48);
            gap = ($urandom_range(0, 3) == 0) ? $urandom_range(13, 40) : $urandom_range(0, 6);
            if (!steady && gap > 0) idle_sender(gap);
        end
        burst_left--;
        i_valid <= 1'b1;
        i_x_coord <= x;
        i_y_coord <= y;
        i_last_point <= last;
        do @(negedge i_clk); while (!in_taken);
        sent_points++;
    endtask

    // A cluster either scattered over the whole plane or bunched around one spot.
    task automatic send_cluster(input int count, input bit bunched);
        logic signed [CW-1:0] base_x;
        logic signed [CW-1:0] base_y;
        logic signed [CW-1:0] dx;
        logic signed [CW-1:0] dy;
        int k;
        base_x = pick_coord();
        base_y = pick_coord();
        for (k = 0; k < count; k++) begin
            if (bunched) begin
                dx = CW'($urandom_range(0, 100));
                dy = CW'($urandom_range(0, 100));
                offer_point(base_x + dx - CW'(50), base_y + dy - CW'(50), k == count - 1);
            end else begin
                offer_point(pick_coord(), pick_coord(), k == count - 1);
            end
        end
    endtask

    task automatic send_random_clusters(input int quota);
        int first;
        int r;
        int count;
        first = sent_points;
        while (sent_points - first < quota) begin
            r = $urandom_range(0, 19);
            if (r < 12) begin
                count = $urandom_range(1, 4);
            end else if (r < 18) begin
                count = $urandom_range(5, 16);
            end else begin
                count = $urandom_range(17, 80);
            end
            steady = ($urandom_range(0, 7) == 0);
            send_cluster(count, $urandom_range(0, 1) == 1);
        end
    endtask

    // Stops offering points until every expected summary has come out.
    task automatic drain_results();
        i_valid <= 1'b0;
        do @(negedge i_clk); while (pending != 0);
    endtask

    initial begin : stimulus
        int k;
        i_rst_n = 1'b0;
        i_valid = 1'b0;
        i_x_coord = '0;
        i_y_coord = '0;
        i_last_point = 1'b0;
        burst_left = 0;
        sent_points = 0;
        steady = 1'b1;
        hold_req = 1'b0;
        repeat (9) @(negedge i_clk);
        i_rst_n <= 1'b1;
        @(negedge i_clk);

        // Single-point clusters at the corners and at the origin.
        offer_point(COORD_MAX, COORD_MIN, 1'b1);
        offer_point(COORD_MIN, COORD_MAX, 1'b1);
        offer_point(0, 0, 1'b1);
        // Widest possible box; sums of -1 over two must truncate to zero.
        offer_point(COORD_MIN, COORD_MAX, 1'b0);
        offer_point(COORD_MAX, COORD_MIN, 1'b1);
        // Negative sum that does not divide evenly, and a positive one.
        offer_point(-5, 7, 1'b0);
        offer_point(-5, 0, 1'b0);
        offer_point(-1, 0, 1'b1);
        // All-positive and all-negative clusters, so a stale zero cannot pose as a bound.
        offer_point(100, 200, 1'b0);
        offer_point(300, 50, 1'b1);
        offer_point(-100, -200, 1'b0);
        offer_point(-50, -300, 1'b0);
        offer_point(-75, -250, 1'b1);
        // Identical points give zero extents.
        offer_point(1234, -4321, 1'b0);
        offer_point(1234, -4321, 1'b0);
        offer_point(1234, -4321, 1'b1);
        // First point lies strictly inside the final box.
        offer_point(10, 10, 1'b0);
        offer_point(-20, 40, 1'b0);
        offer_point(30, -40, 1'b0);
        offer_point(5, 3, 1'b1);

        steady = 1'b0;
        send_random_clusters(RANDOM_POINTS / 2);

        // Long result hold-off while short clusters keep arriving, so the summary
        // queue fills and the point channel stalls.
        drain_results();
        hold_req = 1'b1;
        steady = 1'b1;
        for (k = 0; k < 24; k++) send_cluster(2, 1'b0);
        drain_results();

        steady = 1'b0;
        send_random_clusters(RANDOM_POINTS - RANDOM_POINTS / 2);

        drain_results();
        repeat (SETTLE_CYCLES) @(negedge i_clk);
        $display("Covered %0d points in %0d cluster summaries, %0d of them with dropped points,",
                 points, checked, spilled);
        $display("with a %0d-cycle result hold-off and a full drain in between.", HOLD_CYCLES);
        if (errors == 0 && pending == 0) begin
            $display("Simulation PASSED");
        end else begin
            $display("Simulation FAILED");
        end
        $finish;
    end

endmodule
